// ===== hw/rtl/dmx_pkg.sv =====
// Shared types and constants of the DMX512 frame sender and receiver.
// No dependencies; every other file of the block imports this package.
package dmx_pkg;

  localparam int unsigned IDX_W = 10;
  localparam int unsigned WAIT_W = 7;

  typedef logic [IDX_W-1:0]  slot_idx_t;
  typedef logic [WAIT_W-1:0] wait_t;
  typedef logic [7:0]        byte_t;
  typedef logic [1:0]        mode_t;

  typedef enum logic [2:0] {
    ACT_TX_TICK    = 3'd0,
    ACT_RX_BYTE    = 3'd1,
    ACT_RX_BREAK   = 3'd2,
    ACT_HOST_WRITE = 3'd3,
    ACT_HOST_READ  = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    CFG_RUN_MODE   = 2'd0,
    CFG_MAX_SLOTS  = 2'd1,
    CFG_END_WAIT   = 2'd2,
    CFG_BREAK_WAIT = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    PH_BREAK      = 5'b00001,
    PH_START      = 5'b00010,
    PH_DATA       = 5'b00100,
    PH_IDLE       = 5'b01000,
    PH_BREAK_SENT = 5'b10000
  } phase_e;

  localparam mode_t MODE_SEND = 2'd1;
  localparam mode_t MODE_RECV = 2'd2;

  localparam slot_idx_t MIN_SLOTS = 10'd24;

  localparam mode_t     RST_RUN_MODE   = 2'd0;
  localparam slot_idx_t RST_MAX_SLOTS  = 10'd512;
  localparam wait_t     RST_END_WAIT   = 7'd25;
  localparam wait_t     RST_BREAK_WAIT = 7'd70;

  // Store access issued in the cycle an item is accepted.
  typedef struct packed {
    logic      we;
    logic      re;
    slot_idx_t addr;
    byte_t     wdata;
  } mem_req_t;

  // Result information known at acceptance; the store byte joins it later.
  typedef struct packed {
    logic      tx_push;
    logic      tx_from_mem;
    logic      rd_from_mem;
    logic      line_setting;
    logic      frame_done;
    slot_idx_t frame_slot_count;
  } res_info_t;

endpackage

// ===== hw/rtl/dmx_if.sv =====
// Request channels of the DMX512 block: input items and result items.
// Depends on dmx_pkg for the payload types.
interface dmx_in_if;
  import dmx_pkg::*;

  logic      valid;
  logic      ready;
  logic [2:0] action;
  slot_idx_t slot_index;
  byte_t     data_byte;

  modport source (output valid, action, slot_index, data_byte, input ready);
  modport sink (input valid, action, slot_index, data_byte, output ready);
endinterface

interface dmx_out_if;
  import dmx_pkg::*;

  logic      valid;
  logic      ready;
  logic      tx_push;
  byte_t     tx_byte;
  logic      line_setting;
  logic      frame_done;
  slot_idx_t frame_slot_count;
  byte_t     read_byte;

  modport source (output valid, tx_push, tx_byte, line_setting, frame_done,
                  frame_slot_count, read_byte, input ready);
  modport sink (input valid, tx_push, tx_byte, line_setting, frame_done,
                frame_slot_count, read_byte, output ready);
endinterface

// ===== hw/rtl/dmx_store.sv =====
// Slot store: start code plus data slots in one memory, with a clearing
// pass after reset. Depends on dmx_pkg.
module dmx_store #(
  parameter int unsigned SLOT_COUNT = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dmx_pkg::mem_req_t req_i,
  output logic              busy_o,
  output dmx_pkg::byte_t    rdata_o
);
  import dmx_pkg::*;

  localparam int unsigned DEPTH = SLOT_COUNT + 1;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(SLOT_COUNT);

  byte_t         mem_q [DEPTH];
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic          busy_q, busy_d;
  byte_t         rdata_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  byte_t         wr_data;

  always_comb begin
    clr_cnt_d = clr_cnt_q;
    busy_d = busy_q;
    if (busy_q) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
      if (clr_cnt_q == LAST) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      busy_q <= 1'b1;
    end else begin
      clr_cnt_q <= clr_cnt_d;
      busy_q <= busy_d;
    end
  end

  // Requests only arrive once the clearing pass is over.
  assign wr_en   = busy_q | req_i.we;
  assign wr_addr = busy_q ? clr_cnt_q : req_i.addr[AW-1:0];
  assign wr_data = busy_q ? 8'h00 : req_i.wdata;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr[AW-1:0]];
    end
  end

  assign busy_o  = busy_q;
  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/dmx_ctrl.sv =====
// Configuration registers and frame sequencer of the DMX512 block.
// Updates the state per accepted item and issues the store access.
// Depends on dmx_pkg.
module dmx_ctrl #(
  parameter int unsigned SLOT_COUNT = 512
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  dmx_pkg::slot_idx_t  cfg_data_i,
  input  logic                acc_i,
  input  logic [2:0]          action_i,
  input  dmx_pkg::slot_idx_t  slot_index_i,
  input  dmx_pkg::byte_t      data_byte_i,
  output dmx_pkg::mem_req_t   req_o,
  output dmx_pkg::res_info_t  res_o
);
  import dmx_pkg::*;

  localparam slot_idx_t SLOT_LAST = slot_idx_t'(SLOT_COUNT);

  mode_t     run_mode_q;
  slot_idx_t max_slots_q;
  wait_t     end_wait_q;
  wait_t     break_wait_q;

  phase_e    phase_q, phase_d;
  slot_idx_t pos_q, pos_d;
  wait_t     wait_q, wait_d;
  logic      line_q, line_d;

  slot_idx_t eff_slots;
  slot_idx_t pos_inc;
  logic [WAIT_W:0] wait_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_mode_q <= RST_RUN_MODE;
      max_slots_q <= RST_MAX_SLOTS;
      end_wait_q <= RST_END_WAIT;
      break_wait_q <= RST_BREAK_WAIT;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RUN_MODE:   run_mode_q <= cfg_data_i[1:0];
        CFG_MAX_SLOTS:  max_slots_q <= cfg_data_i;
        CFG_END_WAIT:   end_wait_q <= cfg_data_i[WAIT_W-1:0];
        CFG_BREAK_WAIT: break_wait_q <= cfg_data_i[WAIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (max_slots_q < MIN_SLOTS) begin
      eff_slots = MIN_SLOTS;
    end else if (max_slots_q > SLOT_LAST) begin
      eff_slots = SLOT_LAST;
    end else begin
      eff_slots = max_slots_q;
    end
  end

  assign pos_inc   = pos_q + 10'd1;
  assign wait_next = {1'b0, wait_q} + 8'd1;

  always_comb begin
    phase_d = phase_q;
    pos_d = pos_q;
    wait_d = wait_q;
    line_d = line_q;
    req_o = '0;
    res_o = '0;

    if (cfg_we_i) begin
      // A run_mode write restarts the sequence; slot_position is kept.
      if (cfg_idx_e'(cfg_idx_i) == CFG_RUN_MODE) begin
        phase_d = PH_IDLE;
        wait_d = '0;
        line_d = 1'b0;
      end
    end else if (acc_i) begin
      case (action_e'(action_i))
        ACT_TX_TICK: begin
          if (run_mode_q == MODE_SEND) begin
            case (phase_q)
              PH_BREAK: begin
                line_d = 1'b1;
                phase_d = PH_BREAK_SENT;
                wait_d = '0;
                res_o.tx_push = 1'b1;
              end
              PH_START: begin
                line_d = 1'b0;
                phase_d = PH_DATA;
                pos_d = 10'd1;
                res_o.tx_push = 1'b1;
                res_o.tx_from_mem = 1'b1;
                req_o.re = 1'b1;
                req_o.addr = '0;
              end
              PH_DATA: begin
                if (pos_q > SLOT_LAST) begin
                  phase_d = PH_IDLE;
                  wait_d = '0;
                end else begin
                  res_o.tx_push = 1'b1;
                  res_o.tx_from_mem = 1'b1;
                  req_o.re = 1'b1;
                  req_o.addr = pos_q;
                  pos_d = pos_inc;
                  if (pos_inc > eff_slots) begin
                    phase_d = PH_IDLE;
                    wait_d = '0;
                  end
                end
              end
              PH_BREAK_SENT: begin
                wait_d = wait_next[WAIT_W-1:0];
                if (wait_next > {1'b0, break_wait_q}) begin
                  phase_d = PH_START;
                end
              end
              default: begin
                wait_d = wait_next[WAIT_W-1:0];
                if (wait_next > {1'b0, end_wait_q}) begin
                  phase_d = PH_BREAK;
                end
              end
            endcase
          end
        end
        ACT_RX_BYTE: begin
          if (run_mode_q == MODE_RECV) begin
            if (phase_q == PH_BREAK) begin
              // Only a zero start code opens storage of the frame.
              if (data_byte_i == 8'h00) begin
                phase_d = PH_DATA;
                pos_d = 10'd1;
              end else begin
                phase_d = PH_IDLE;
              end
            end else if (phase_q == PH_DATA) begin
              if (pos_q > SLOT_LAST) begin
                phase_d = PH_IDLE;
              end else begin
                req_o.we = 1'b1;
                req_o.addr = pos_q;
                req_o.wdata = data_byte_i;
                pos_d = pos_inc;
                if (pos_inc > SLOT_LAST) begin
                  phase_d = PH_IDLE;
                end
              end
            end
          end
        end
        ACT_RX_BREAK: begin
          if (run_mode_q == MODE_RECV) begin
            phase_d = PH_BREAK;
            if (pos_q != '0) begin
              res_o.frame_done = 1'b1;
              res_o.frame_slot_count = pos_q;
            end
            pos_d = '0;
          end
        end
        ACT_HOST_WRITE: begin
          if (slot_index_i <= SLOT_LAST) begin
            req_o.we = 1'b1;
            req_o.addr = slot_index_i;
            req_o.wdata = data_byte_i;
          end
        end
        ACT_HOST_READ: begin
          if (slot_index_i <= SLOT_LAST) begin
            req_o.re = 1'b1;
            req_o.addr = slot_index_i;
            res_o.rd_from_mem = 1'b1;
          end
        end
        default: ;
      endcase
    end

    res_o.line_setting = line_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q <= '0;
      wait_q <= '0;
      line_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_q <= pos_d;
      wait_q <= wait_d;
      line_q <= line_d;
    end
  end

endmodule

// ===== hw/rtl/dmx512_frame_sender_receiver.sv =====
// DMX512 sender and receiver sharing a store of start code plus SLOT_COUNT
// slots. One request is accepted per clock cycle unless the store is
// clearing or the output holds back; its result passes through the store
// read and the output register. The sequencer state is updated in the
// cycle of acceptance and the store is read there with a registered output.
// After reset the store is cleared, during which no request is accepted;
// configuration writes are taken at any time and must only be issued while
// no request is in flight.
// Depends on dmx_pkg, dmx_if, dmx_ctrl and dmx_store.
module dmx512_frame_sender_receiver #(
  parameter int unsigned SLOT_COUNT = 512
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  dmx_pkg::slot_idx_t cfg_data_i,
  dmx_in_if.sink             in_if,
  dmx_out_if.source          out_if
);
  import dmx_pkg::*;

  mem_req_t  req;
  res_info_t res_info;
  logic      busy;
  byte_t     rdata;
  logic      acc;

  logic      p_valid_q, p_valid_d;
  res_info_t p_info_q;
  logic      p_move;

  logic      o_valid_q, o_valid_d;
  logic      o_tx_push_q;
  byte_t     o_tx_byte_q;
  logic      o_line_q;
  logic      o_done_q;
  slot_idx_t o_count_q;
  byte_t     o_read_q;

  assign p_move = p_valid_q & (~o_valid_q | out_if.ready);
  assign in_if.ready = ~busy & (~p_valid_q | p_move);
  assign acc = in_if.valid & in_if.ready;

  dmx_ctrl #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .acc_i       (acc),
    .action_i    (in_if.action),
    .slot_index_i(in_if.slot_index),
    .data_byte_i (in_if.data_byte),
    .req_o       (req),
    .res_o       (res_info)
  );

  dmx_store #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .busy_o (busy),
    .rdata_o(rdata)
  );

  always_comb begin
    p_valid_d = p_valid_q;
    if (acc) begin
      p_valid_d = 1'b1;
    end else if (p_move) begin
      p_valid_d = 1'b0;
    end
    o_valid_d = o_valid_q;
    if (p_move) begin
      o_valid_d = 1'b1;
    end else if (out_if.ready) begin
      o_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      p_valid_q <= p_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      p_info_q <= res_info;
    end
    // The store read data holds while this stage waits, since nothing new
    // is accepted until it moves on.
    if (p_move) begin
      o_tx_push_q <= p_info_q.tx_push;
      o_tx_byte_q <= p_info_q.tx_from_mem ? rdata : 8'h00;
      o_line_q <= p_info_q.line_setting;
      o_done_q <= p_info_q.frame_done;
      o_count_q <= p_info_q.frame_slot_count;
      o_read_q <= p_info_q.rd_from_mem ? rdata : 8'h00;
    end
  end

  assign out_if.valid            = o_valid_q;
  assign out_if.tx_push          = o_tx_push_q;
  assign out_if.tx_byte          = o_tx_byte_q;
  assign out_if.line_setting     = o_line_q;
  assign out_if.frame_done       = o_done_q;
  assign out_if.frame_slot_count = o_count_q;
  assign out_if.read_byte        = o_read_q;

endmodule
